@@ rtl/slht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slht_pkg
// Shared widths, constants and request/result types of the segment and
// label hit test.
// ----------------------------------------------------------------------------
package slht_pkg;

    // Coordinate width of one input field.
    localparam int COORD_W   = 16;
    // Difference of two coordinates.
    localparam int DIFF_W    = COORD_W + 1;
    // Signed product of two differences.
    localparam int PROD_W    = 2 * DIFF_W;
    // Sum of two products (squared length, dot and cross products).
    localparam int SUM_W     = PROD_W + 1;
    // Label box offsets are formed at this width.
    localparam int BOX_W     = DIFF_W + 1;
    // A cross magnitude at or above 2^MAG_W always squares past the bound.
    localparam int MAG_W     = COORD_W + 3;
    localparam int MAG2_W    = 2 * MAG_W;

    // Near test: squared distance below 2^NEAR_SHIFT (a distance of 4).
    localparam int NEAR_SHIFT = 4;
    localparam int NEAR_SQ    = 1 << NEAR_SHIFT;
    localparam int BND_W      = SUM_W + NEAR_SHIFT;

    // Label registers.
    localparam int LBL_W     = 10;
    localparam int LABEL_PAD = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_HEIGHT = CFG_IDX_W'(1);

    // Pipeline depth, one valid bit per stage.
    localparam int NUM_STAGES = 6;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
    } pt_req_t;

    typedef struct packed {
        logic hit;
        logic near_line;
        logic in_label;
    } hit_rsp_t;

endpackage

@@ rtl/segment_and_label_hit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_and_label_hit_test
// Tests a query point against a line segment and the label box drawn at the
// segment midpoint, one request per cycle while res_ready is high, through a six stage pipeline.
// ----------------------------------------------------------------------------
//
// Usage:
//   A request on the pt channel (pt_valid/pt_ready/pt) carries the two
//   segment endpoints and the query point. One result per request leaves on
//   the res channel (res_valid/res_ready/res), in request order. near_line is
//   set when the point is closer than 4 to the segment, in_label when it lies
//   in the label box, and hit is the OR of the two.
//   The cfg channel writes the label width (index 0) and label height
//   (index 1); only the low ten data bits are kept and other indexes are
//   dropped. cfg_ready is always high. Write it only while no request is in
//   flight, since the label size is sampled as a request passes stage two.
//
// Timing:
//   The accepting edge loads stage one; the request then moves on through
//   the stages in order as they advance, and res_valid is set once it
//   reaches stage six. A new request is accepted every cycle while res_ready
//   is high, as every stage takes new contents whenever its contents move on.
//
// Reset and stalls:
//   rst_n clears the stage valid bits and both label registers. When the
//   receiver holds res_ready low, the result stays put and the pipeline
//   compresses bubbles; pt_ready drops only once all six stages are full.
//
// Stages: 1 differences and midpoint, 2 products and label box, 3 sums,
// 4 region select and cross magnitude, 5 cross square, 6 final compare.
// ----------------------------------------------------------------------------
module segment_and_label_hit_test
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 pt_valid,
    output logic                                 pt_ready,
    input  slht_pkg::pt_req_t                    pt,

    output logic                                 res_valid,
    input  logic                                 res_ready,
    output slht_pkg::hit_rsp_t                   res,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [slht_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [slht_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [slht_pkg::LBL_W-1:0] lw_reg;
    logic [slht_pkg::LBL_W-1:0] lh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg <= '0;
            lh_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                slht_pkg::CFG_LABEL_WIDTH:
                begin
                    lw_reg <= cfg_data[slht_pkg::LBL_W-1:0];
                end
                slht_pkg::CFG_LABEL_HEIGHT:
                begin
                    lh_reg <= cfg_data[slht_pkg::LBL_W-1:0];
                end
                default:
                begin
                    // Writes to unknown indexes are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and advance chain. A stage takes new contents when
    // it is empty or when its contents move on; bubbles are squeezed out.
    // ------------------------------------------------------------------
    logic [slht_pkg::NUM_STAGES-1:0] v_reg;
    logic [slht_pkg::NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[slht_pkg::NUM_STAGES-1] = !v_reg[slht_pkg::NUM_STAGES-1] || res_ready;
        for (int k = slht_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign pt_ready  = adv[0];
    assign res_valid = v_reg[slht_pkg::NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= pt_valid;
            end
            for (int k = 1; k < slht_pkg::NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: coordinate differences and the truncated midpoint.
    // ------------------------------------------------------------------
    logic signed [slht_pkg::DIFF_W-1:0]  s1_dx_reg, s1_dy_reg, s1_qx_reg, s1_qy_reg;
    logic signed [slht_pkg::DIFF_W-1:0]  s1_fx_reg, s1_fy_reg, s1_mx_reg, s1_my_reg;
    logic signed [slht_pkg::COORD_W-1:0] s1_px_reg, s1_py_reg;

    logic signed [slht_pkg::DIFF_W-1:0]  s1_dx_next, s1_dy_next, s1_qx_next, s1_qy_next;
    logic signed [slht_pkg::DIFF_W-1:0]  s1_fx_next, s1_fy_next, s1_mx_next, s1_my_next;
    logic signed [slht_pkg::DIFF_W-1:0]  msum_x, msum_y, mrnd_x, mrnd_y;

    always_comb
    begin
        s1_dx_next = slht_pkg::DIFF_W'(pt.end_x)   - slht_pkg::DIFF_W'(pt.start_x);
        s1_dy_next = slht_pkg::DIFF_W'(pt.end_y)   - slht_pkg::DIFF_W'(pt.start_y);
        s1_qx_next = slht_pkg::DIFF_W'(pt.query_x) - slht_pkg::DIFF_W'(pt.start_x);
        s1_qy_next = slht_pkg::DIFF_W'(pt.query_y) - slht_pkg::DIFF_W'(pt.start_y);
        s1_fx_next = slht_pkg::DIFF_W'(pt.query_x) - slht_pkg::DIFF_W'(pt.end_x);
        s1_fy_next = slht_pkg::DIFF_W'(pt.query_y) - slht_pkg::DIFF_W'(pt.end_y);

        // Halving rounds toward zero: add one to a negative sum first.
        msum_x = slht_pkg::DIFF_W'(pt.start_x) + slht_pkg::DIFF_W'(pt.end_x);
        msum_y = slht_pkg::DIFF_W'(pt.start_y) + slht_pkg::DIFF_W'(pt.end_y);
        mrnd_x = msum_x + $signed({{(slht_pkg::DIFF_W-1){1'b0}}, msum_x[slht_pkg::DIFF_W-1]});
        mrnd_y = msum_y + $signed({{(slht_pkg::DIFF_W-1){1'b0}}, msum_y[slht_pkg::DIFF_W-1]});
        s1_mx_next = mrnd_x >>> 1;
        s1_my_next = mrnd_y >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_dx_reg <= s1_dx_next;
            s1_dy_reg <= s1_dy_next;
            s1_qx_reg <= s1_qx_next;
            s1_qy_reg <= s1_qy_next;
            s1_fx_reg <= s1_fx_next;
            s1_fy_reg <= s1_fy_next;
            s1_mx_reg <= s1_mx_next;
            s1_my_reg <= s1_my_next;
            s1_px_reg <= pt.query_x;
            s1_py_reg <= pt.query_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: all products, and the label box test.
    // The box spans [mid, mid + 2*floor((size+12)/2)] on each axis.
    // ------------------------------------------------------------------
    logic signed [slht_pkg::PROD_W-1:0] s2_dxdx_reg, s2_dydy_reg, s2_qxdx_reg, s2_qydy_reg;
    logic signed [slht_pkg::PROD_W-1:0] s2_qxdy_reg, s2_qydx_reg, s2_qxqx_reg, s2_qyqy_reg;
    logic signed [slht_pkg::PROD_W-1:0] s2_fxfx_reg, s2_fyfy_reg;
    logic                               s2_box_reg;

    logic [slht_pkg::LBL_W:0]           bw_sum, bh_sum, bw, bh;
    logic signed [slht_pkg::BOX_W-1:0]  offs_x, offs_y;
    logic                               s2_box_next;

    always_comb
    begin
        bw_sum = (slht_pkg::LBL_W+1)'(lw_reg) + (slht_pkg::LBL_W+1)'(slht_pkg::LABEL_PAD);
        bh_sum = (slht_pkg::LBL_W+1)'(lh_reg) + (slht_pkg::LBL_W+1)'(slht_pkg::LABEL_PAD);
        bw     = {bw_sum[slht_pkg::LBL_W:1], 1'b0};
        bh     = {bh_sum[slht_pkg::LBL_W:1], 1'b0};

        offs_x = slht_pkg::BOX_W'(s1_px_reg) - slht_pkg::BOX_W'(s1_mx_reg);
        offs_y = slht_pkg::BOX_W'(s1_py_reg) - slht_pkg::BOX_W'(s1_my_reg);

        s2_box_next = !offs_x[slht_pkg::BOX_W-1]
                   && (offs_x <= $signed(slht_pkg::BOX_W'(bw)))
                   && !offs_y[slht_pkg::BOX_W-1]
                   && (offs_y <= $signed(slht_pkg::BOX_W'(bh)));
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_dxdx_reg <= s1_dx_reg * s1_dx_reg;
            s2_dydy_reg <= s1_dy_reg * s1_dy_reg;
            s2_qxdx_reg <= s1_qx_reg * s1_dx_reg;
            s2_qydy_reg <= s1_qy_reg * s1_dy_reg;
            s2_qxdy_reg <= s1_qx_reg * s1_dy_reg;
            s2_qydx_reg <= s1_qy_reg * s1_dx_reg;
            s2_qxqx_reg <= s1_qx_reg * s1_qx_reg;
            s2_qyqy_reg <= s1_qy_reg * s1_qy_reg;
            s2_fxfx_reg <= s1_fx_reg * s1_fx_reg;
            s2_fyfy_reg <= s1_fy_reg * s1_fy_reg;
            s2_box_reg  <= s2_box_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared length, dot and cross products, squared distances
    // to both endpoints.
    // ------------------------------------------------------------------
    logic signed [slht_pkg::SUM_W-1:0] s3_len2_reg, s3_dot_reg, s3_cross_reg;
    logic signed [slht_pkg::SUM_W-1:0] s3_dq_reg, s3_de_reg;
    logic                              s3_box_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_len2_reg  <= slht_pkg::SUM_W'(s2_dxdx_reg) + slht_pkg::SUM_W'(s2_dydy_reg);
            s3_dot_reg   <= slht_pkg::SUM_W'(s2_qxdx_reg) + slht_pkg::SUM_W'(s2_qydy_reg);
            s3_cross_reg <= slht_pkg::SUM_W'(s2_qxdy_reg) - slht_pkg::SUM_W'(s2_qydx_reg);
            s3_dq_reg    <= slht_pkg::SUM_W'(s2_qxqx_reg) + slht_pkg::SUM_W'(s2_qyqy_reg);
            s3_de_reg    <= slht_pkg::SUM_W'(s2_fxfx_reg) + slht_pkg::SUM_W'(s2_fyfy_reg);
            s3_box_reg   <= s2_box_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick the region. A zero length segment or a projection
    // before the start uses the start point, one past the end uses the
    // end point, anything else uses the perpendicular distance.
    // ------------------------------------------------------------------
    logic [slht_pkg::MAG_W-1:0]        s4_mag_reg;
    logic                              s4_big_reg, s4_use_perp_reg, s4_near_ep_reg;
    logic signed [slht_pkg::SUM_W-1:0] s4_len2_reg;
    logic                              s4_box_reg;

    logic [slht_pkg::SUM_W-1:0]        cross_abs;
    logic                              close_s, close_e;
    logic                              s4_use_perp_next, s4_near_ep_next;

    always_comb
    begin
        cross_abs = s3_cross_reg[slht_pkg::SUM_W-1] ? slht_pkg::SUM_W'(-s3_cross_reg)
                                                    : slht_pkg::SUM_W'(s3_cross_reg);
        close_s = s3_dq_reg < slht_pkg::SUM_W'(slht_pkg::NEAR_SQ);
        close_e = s3_de_reg < slht_pkg::SUM_W'(slht_pkg::NEAR_SQ);

        priority if (s3_len2_reg == '0 || s3_dot_reg[slht_pkg::SUM_W-1])
        begin
            s4_use_perp_next = 1'b0;
            s4_near_ep_next  = close_s;
        end
        else if (s3_dot_reg > s3_len2_reg)
        begin
            s4_use_perp_next = 1'b0;
            s4_near_ep_next  = close_e;
        end
        else
        begin
            s4_use_perp_next = 1'b1;
            s4_near_ep_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_mag_reg      <= cross_abs[slht_pkg::MAG_W-1:0];
            s4_big_reg      <= |cross_abs[slht_pkg::SUM_W-1:slht_pkg::MAG_W];
            s4_use_perp_reg <= s4_use_perp_next;
            s4_near_ep_reg  <= s4_near_ep_next;
            s4_len2_reg     <= s3_len2_reg;
            s4_box_reg      <= s3_box_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: square the low MAG_W bits of the cross magnitude.
    // ------------------------------------------------------------------
    logic [slht_pkg::MAG2_W-1:0]       s5_mag2_reg;
    logic                              s5_big_reg, s5_use_perp_reg, s5_near_ep_reg;
    logic signed [slht_pkg::SUM_W-1:0] s5_len2_reg;
    logic                              s5_box_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_mag2_reg     <= slht_pkg::MAG2_W'(s4_mag_reg) * slht_pkg::MAG2_W'(s4_mag_reg);
            s5_big_reg      <= s4_big_reg;
            s5_use_perp_reg <= s4_use_perp_reg;
            s5_near_ep_reg  <= s4_near_ep_reg;
            s5_len2_reg     <= s4_len2_reg;
            s5_box_reg      <= s4_box_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: perpendicular test cross^2 < 16 * len2, final result.
    // This stage is the output register.
    // ------------------------------------------------------------------
    slht_pkg::hit_rsp_t           s6_rsp_reg;
    slht_pkg::hit_rsp_t           s6_rsp_next;
    logic [slht_pkg::BND_W-1:0]   bound;
    logic                         near_perp, near_any;

    always_comb
    begin
        bound     = {s5_len2_reg, {slht_pkg::NEAR_SHIFT{1'b0}}};
        near_perp = !s5_big_reg && (slht_pkg::BND_W'(s5_mag2_reg) < bound);
        near_any  = s5_use_perp_reg ? near_perp : s5_near_ep_reg;

        s6_rsp_next.near_line = near_any;
        s6_rsp_next.in_label  = s5_box_reg;
        s6_rsp_next.hit       = near_any || s5_box_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_rsp_reg <= s6_rsp_next;
        end
    end

    assign res = s6_rsp_reg;

`ifndef SYNTHESIS
    // An accepted request always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pt_valid && pt_ready) |=> v_reg[0])
        else $error("accepted request did not enter stage one");

    // A stalled result does not let the stage behind it drop its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[5] && !res_ready && v_reg[4]) |=> (v_reg[4] && v_reg[5]))
        else $error("stage five lost an entry during an output stall");

    // Backpressure reaches the input only when every stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pt_ready |-> (&v_reg))
        else $error("input stalled with a free pipeline stage");

    // A zero length segment never takes the perpendicular path.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && s4_len2_reg == '0) |-> !s4_use_perp_reg)
        else $error("zero length segment selected perpendicular test");
`endif

endmodule
